// ===== rtl/crcc_pkg.sv =====
// Shared constants and types for the call reference cross-connect.
`default_nettype none

package crcc_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = IDX_W + 1;
	localparam int REF_W       = 32;

	// incoming message kinds
	localparam logic [3:0] KIND_SETUP   = 4'd1;
	localparam logic [3:0] KIND_REL_IND = 4'd7;
	localparam logic [3:0] KIND_REL_CNF = 4'd8;

	// outgoing message kinds
	localparam logic [2:0] OUT_SETUP_REQ = 3'd1;
	localparam logic [2:0] OUT_REL_REQ   = 3'd7;

	// release causes
	localparam logic [1:0] CAUSE_NONE    = 2'd0;
	localparam logic [1:0] CAUSE_BAD_REF = 2'd1;
	localparam logic [1:0] CAUSE_FULL    = 2'd2;

	typedef struct packed {
		logic [REF_W-1:0] near_ref;
		logic [REF_W-1:0] far_ref;
	} entry_t;

endpackage

`default_nettype wire

// ===== rtl/call_reference_cross_connect_core.sv =====
// Call reference cross-connect: pair table walk, allocate, rename and release.
// The table walk reads one pair per cycle from the pair memory and
// stops at the first hit (or first free entry for a setup).
// Throughput: one message at a time; busy stays high until the walk and update end.
// Reset clears valid bits, reference counter and control; pair memory is not cleared.
// Results cannot be stalled: each one is shown for a single cycle under done.
`default_nettype none

module call_reference_cross_connect_core
	import crcc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [3:0]       message_kind,
	input  wire logic [REF_W-1:0] call_reference,
	output logic                  done,
	output logic [2:0]            out_kind,
	output logic [REF_W-1:0]      out_reference,
	output logic [1:0]            cause_code
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]             state_q;
	logic [3:0]             kind_q;
	logic [REF_W-1:0]       ref_q;
	logic [CNT_W-1:0]       issue_q;
	logic                   pend_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [REF_W-1:0]       counter_q;
	logic                   hit_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic [REF_W-1:0]       remote_q;
	logic                   free_q;
	logic [IDX_W-1:0]       free_idx_q;

	entry_t                 mem [TABLE_DEPTH];
	entry_t                 rd_s1;
	logic                   rd_en;
	logic                   wr_en;
	entry_t                 wr_data;
	logic [REF_W-1:0]       counter_inc;

	logic                   is_setup;
	logic                   ent_valid;
	logic                   near_hit;
	logic                   far_hit;
	logic                   ent_hit;
	logic                   ent_free;
	logic                   last_s1;
	logic                   stop;

	assign busy        = (state_q != ST_IDLE);
	assign is_setup    = (kind_q == KIND_SETUP);
	assign counter_inc = counter_q + REF_W'(1);

	assign rd_en = (state_q == ST_SCAN) && (issue_q < CNT_W'(TABLE_DEPTH)) && !stop;
	assign wr_en = (state_q == ST_FINISH) && is_setup && free_q;
	assign wr_data = '{near_ref: ref_q, far_ref: counter_inc};

	// entry check in the cycle after its read
	assign ent_valid = valid_q[idx_s1];
	assign near_hit  = (rd_s1.near_ref == ref_q);
	assign far_hit   = (rd_s1.far_ref == ref_q);
	assign ent_hit   = pend_s1 && ent_valid && (near_hit || far_hit);
	assign ent_free  = pend_s1 && !ent_valid;
	assign last_s1   = pend_s1 && (idx_s1 == IDX_W'(TABLE_DEPTH - 1));
	assign stop      = is_setup ? ent_free : ent_hit;

	// pair memory, one read and one write port, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[free_idx_q] <= wr_data;
		end
		if (rd_en) begin
			rd_s1 <= mem[issue_q[IDX_W-1:0]];
		end
	end

	// payload captures
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_q <= message_kind;
			ref_q  <= call_reference;
		end
		if (rd_en) begin
			idx_s1 <= issue_q[IDX_W-1:0];
		end
		if (ent_hit && !hit_q) begin
			hit_idx_q <= idx_s1;
			remote_q  <= near_hit ? rd_s1.far_ref : rd_s1.near_ref;
		end
		if (ent_free && !free_q) begin
			free_idx_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			issue_q       <= '0;
			pend_s1       <= 1'b0;
			valid_q       <= '0;
			counter_q     <= '0;
			hit_q         <= 1'b0;
			free_q        <= 1'b0;
			done          <= 1'b0;
			out_kind      <= '0;
			out_reference <= '0;
			cause_code    <= CAUSE_NONE;
		end else begin
			done    <= 1'b0;
			pend_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						issue_q <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (ent_hit) begin
						hit_q <= 1'b1;
					end
					if (ent_free) begin
						free_q <= 1'b1;
					end
					if (stop || last_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
					if (kind_q == KIND_REL_CNF) begin
						if (hit_q) begin
							valid_q[hit_idx_q] <= 1'b0;
						end
					end else if (is_setup) begin
						done <= 1'b1;
						if (free_q) begin
							counter_q           <= counter_inc;
							valid_q[free_idx_q] <= 1'b1;
							out_kind            <= OUT_SETUP_REQ;
							out_reference       <= counter_inc;
							cause_code          <= CAUSE_NONE;
						end else begin
							out_kind      <= OUT_REL_REQ;
							out_reference <= ref_q;
							cause_code    <= CAUSE_FULL;
						end
					end else if (!hit_q) begin
						done          <= 1'b1;
						out_kind      <= OUT_REL_REQ;
						out_reference <= ref_q;
						cause_code    <= CAUSE_BAD_REF;
					end else if (kind_q <= KIND_REL_IND) begin
						done          <= 1'b1;
						out_kind      <= kind_q[2:0];
						out_reference <= remote_q;
						cause_code    <= CAUSE_NONE;
						if (kind_q == KIND_REL_IND) begin
							valid_q[hit_idx_q] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a result ends the message: the block is free again when it shows
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	// at most one result per accepted message
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("repeated result");

	// error causes come only with a release request
	a_cause_rel: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cause_code != CAUSE_NONE) |-> (out_kind == OUT_REL_REQ))
		else $error("cause without release");

	// a table-full release keeps the reference counter unchanged
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cause_code == CAUSE_FULL) |-> $stable(counter_q))
		else $error("counter moved on table full");

endmodule

`default_nettype wire

// ===== dv/crcc_checker.sv =====
// Checker for the call reference cross-connect: pair table predictor and result compare.
`timescale 1ns / 100ps

module crcc_checker
	import crcc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             busy,
	input  wire logic [3:0]       message_kind,
	input  wire logic [REF_W-1:0] call_reference,
	input  wire logic             done,
	input  wire logic [2:0]       out_kind,
	input  wire logic [REF_W-1:0] out_reference,
	input  wire logic [1:0]       cause_code,
	output int                    fail_count,
	output int                    pending_count
);

	typedef struct packed {
		logic [2:0]       kind;
		logic [REF_W-1:0] peer;
		logic [1:0]       cause;
	} routed_msg_t;

	// shadow pair table
	logic             pair_live [TABLE_DEPTH];
	logic [REF_W-1:0] near_tab  [TABLE_DEPTH];
	logic [REF_W-1:0] far_tab   [TABLE_DEPTH];
	logic [REF_W-1:0] far_counter;

	routed_msg_t routed_q [$];
	int          mismatches = 0;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string what, input logic [REF_W-1:0] got,
			input logic [REF_W-1:0] want);
		$display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic route_beat(input logic [3:0] kind, input logic [REF_W-1:0] cref);
		int               hit;
		int               slot;
		logic [REF_W-1:0] remote;
		routed_msg_t      msg;
		hit    = -1;
		slot   = -1;
		remote = '0;
		// first hit wins, near side before far side in each entry
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (hit < 0 && pair_live[i]) begin
				if (near_tab[i] == cref) begin
					hit    = i;
					remote = far_tab[i];
				end else if (far_tab[i] == cref) begin
					hit    = i;
					remote = near_tab[i];
				end
			end
		end
		if (kind == KIND_REL_CNF) begin
			if (hit >= 0)
				pair_live[hit] = 1'b0;
		end else if (kind == KIND_SETUP) begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				if (slot < 0 && !pair_live[i])
					slot = i;
			if (slot < 0) begin
				msg = '{kind: OUT_REL_REQ, peer: cref, cause: CAUSE_FULL};
			end else begin
				far_counter     = far_counter + REF_W'(1);
				pair_live[slot] = 1'b1;
				near_tab[slot]  = cref;
				far_tab[slot]   = far_counter;
				msg = '{kind: OUT_SETUP_REQ, peer: far_counter, cause: CAUSE_NONE};
			end
			routed_q.push_back(msg);
		end else if (hit < 0) begin
			msg = '{kind: OUT_REL_REQ, peer: cref, cause: CAUSE_BAD_REF};
			routed_q.push_back(msg);
		end else if (kind <= KIND_REL_IND) begin
			msg = '{kind: kind[2:0], peer: remote, cause: CAUSE_NONE};
			routed_q.push_back(msg);
			if (kind == KIND_REL_IND)
				pair_live[hit] = 1'b0;
		end
		// known reference with other or undefined kind: dropped, no state change
	endtask

	task automatic check_result();
		routed_msg_t want;
		if (routed_q.size() == 0) begin
			report_mismatch("unexpected result, kind", REF_W'(out_kind), '0);
		end else begin
			want = routed_q.pop_front();
			if (out_kind !== want.kind)
				report_mismatch("out_kind", REF_W'(out_kind), REF_W'(want.kind));
			if (out_reference !== want.peer)
				report_mismatch("out_reference", out_reference, want.peer);
			if (cause_code !== want.cause)
				report_mismatch("cause_code", REF_W'(cause_code), REF_W'(want.cause));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				pair_live[i] = 1'b0;
				near_tab[i]  = '0;
				far_tab[i]   = '0;
			end
			far_counter = '0;
			routed_q.delete();
		end else begin
			// a result leaving on the same edge as a new beat belongs to the older beat
			if (done)
				check_result();
			if (start && !busy)
				route_beat(message_kind, call_reference);
		end
		pending_count = routed_q.size();
	end

endmodule

// ===== dv/tb.sv =====
// Testbench top: message stimulus in bursts, block instance, checker and verdict.
`timescale 1ns / 100ps

module tb;
	import crcc_pkg::*;

	localparam logic [3:0] KIND_VOICE       = 4'd0;
	localparam logic [3:0] KIND_CALL_CONF   = 4'd2;
	localparam logic [3:0] KIND_ALERT       = 4'd3;
	localparam logic [3:0] KIND_SETUP_CNF   = 4'd4;
	localparam logic [3:0] KIND_SETUP_COMPL = 4'd5;
	localparam logic [3:0] KIND_DISC        = 4'd6;
	localparam logic [3:0] KIND_OTHER       = 4'd9;
	localparam logic [3:0] KIND_UNDEF_MID   = 4'd12;
	localparam logic [3:0] KIND_UNDEF_HI    = 4'd15;

	localparam int RANDOM_BEATS = 750;
	localparam int PHASE_BEATS  = 125;
	localparam int CYCLE_LIMIT  = 400000;

	logic             clk            = 1'b0;
	logic             arst_n         = 1'b0;
	logic             start          = 1'b0;
	logic [3:0]       message_kind   = '0;
	logic [REF_W-1:0] call_reference = '0;
	logic             busy;
	logic             done;
	logic [2:0]       out_kind;
	logic [REF_W-1:0] out_reference;
	logic [1:0]       cause_code;
	int               fail_count;
	int               pending_count;

	// stimulus bookkeeping only: recent setup references and setups sent
	logic [REF_W-1:0] ref_pool [$];
	int               setups_sent = 0;
	int               burst_left  = 1;

	initial forever #5 clk = ~clk;

	call_reference_cross_connect_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.message_kind   (message_kind),
		.call_reference (call_reference),
		.done           (done),
		.out_kind       (out_kind),
		.out_reference  (out_reference),
		.cause_code     (cause_code)
	);

	crcc_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.message_kind   (message_kind),
		.call_reference (call_reference),
		.done           (done),
		.out_kind       (out_kind),
		.out_reference  (out_reference),
		.cause_code     (cause_code),
		.fail_count     (fail_count),
		.pending_count  (pending_count)
	);

	task automatic send_beat(input logic [3:0] kind, input logic [REF_W-1:0] cref);
		int gap;
		message_kind   <= kind;
		call_reference <= cref;
		start          <= 1'b1;
		do @(posedge clk); while (busy);
		if (kind == KIND_SETUP) begin
			setups_sent++;
			ref_pool.push_back(cref);
			if (ref_pool.size() > 32)
				void'(ref_pool.pop_front());
		end
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 40)
				: $urandom_range(1, 6);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 25);
			// zero gap keeps start high into the next burst
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic logic [REF_W-1:0] pick_ref();
		int lo;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				if (ref_pool.size() > 0)
					return ref_pool[$urandom_range(0, ref_pool.size() - 1)];
				return $urandom();
			end
			5, 6, 7: begin
				// far sides come from the counter, so aim just under setups sent
				if (setups_sent == 0)
					return $urandom();
				lo = (setups_sent > 60) ? setups_sent - 60 : 1;
				return $urandom_range(lo, setups_sent);
			end
			8: return $urandom();
			default: return $urandom_range(0, 1) ? '0 : '1;
		endcase
	endfunction

	function automatic logic [REF_W-1:0] new_setup_ref();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return $urandom_range(1, 64);   // may collide with a far side
			3: return pick_ref();              // duplicate setup
			default: return $urandom();
		endcase
	endfunction

	task automatic random_beat(input bit fill);
		int         roll;
		int         pick;
		logic [3:0] kind;
		roll = $urandom_range(0, 99);
		if (roll < (fill ? 45 : 15)) begin
			send_beat(KIND_SETUP, new_setup_ref());
		end else if (roll < (fill ? 55 : 45)) begin
			kind = $urandom_range(0, 1) ? KIND_REL_IND : KIND_REL_CNF;
			send_beat(kind, pick_ref());
		end else if (roll < 90) begin
			pick = $urandom_range(0, 6);
			case (pick)
				0:       kind = KIND_VOICE;
				1:       kind = KIND_OTHER;
				default: kind = pick[3:0];
			endcase
			send_beat(kind, pick_ref());
		end else begin
			send_beat(4'($urandom_range(0, 15)), $urandom());
		end
	endtask

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: every lookup misses
		send_beat(KIND_VOICE, '0);
		send_beat(KIND_OTHER, '1);
		send_beat(KIND_REL_CNF, 32'h1234_5678);
		send_beat(KIND_UNDEF_HI, 32'h8000_0001);
		// pairs (ffffffff,1) (0,2) (1,3): reference 1 sits on both sides
		send_beat(KIND_SETUP, '1);
		send_beat(KIND_SETUP, '0);
		send_beat(KIND_SETUP, 32'd1);
		send_beat(KIND_ALERT, 32'd1);
		send_beat(KIND_CALL_CONF, '0);
		send_beat(KIND_SETUP_CNF, 32'd2);
		send_beat(KIND_SETUP_COMPL, '1);
		send_beat(KIND_DISC, 32'd3);
		send_beat(KIND_VOICE, '0);
		send_beat(KIND_SETUP, '0);
		// known reference with other or undefined kind is dropped
		send_beat(KIND_OTHER, '0);
		send_beat(KIND_UNDEF_MID, '0);
		send_beat(KIND_REL_IND, '1);
		send_beat(KIND_ALERT, 32'd1);
		send_beat(KIND_REL_CNF, '0);
		send_beat(KIND_REL_CNF, '0);
		send_beat(KIND_CALL_CONF, '0);
		send_beat(KIND_REL_IND, 32'hdead_beef);

		// alternate setup-heavy and release-heavy phases so the table fills and drains
		for (int n = 0; n < RANDOM_BEATS; n++)
			random_beat(((n / PHASE_BEATS) % 2) == 0);

		start <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		if (fail_count == 0 && pending_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/crcc_pkg.sv
rtl/call_reference_cross_connect_core.sv
dv/crcc_checker.sv
dv/tb.sv
